FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// types and constants of the button sequence detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

	localparam int unsigned SAMPLE_W    = 11;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned STEP_W      = 4;
	localparam int unsigned TIMEOUT_W   = 16;
	localparam int unsigned MASK_WORD_W = 55;
	localparam int unsigned SLOTS       = 5;
	localparam int unsigned MAX_STEPS   = 10;
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned PADDR_W     = 5;

	localparam logic [SAMPLE_W-1:0]  IDLE_SAMPLE     = 11'h7FF;
	localparam logic [STEP_W-1:0]    SEQ_LEN_RESET   = 4'd10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd1000;

	typedef enum logic [1:0] {
		REG_STEP_MASKS_LOW  = 2'd0,
		REG_STEP_MASKS_HIGH = 2'd1,
		REG_SEQUENCE_LENGTH = 2'd2,
		REG_TIMEOUT_MS      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [MASK_WORD_W-1:0] step_masks_low;
		logic [MASK_WORD_W-1:0] step_masks_high;
		logic [STEP_W-1:0]      sequence_length;
		logic [TIMEOUT_W-1:0]   timeout_ms;
	} bsd_cfg_t;

	// mask of one step, zero beyond the last step
	function automatic logic [SAMPLE_W-1:0] step_mask(
		input logic [MASK_WORD_W-1:0] low,
		input logic [MASK_WORD_W-1:0] high,
		input logic [STEP_W-1:0]      idx
	);
		logic [SAMPLE_W-1:0] m;
		m = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (k < MAX_STEPS && idx == STEP_W'(k))
				m = low[SAMPLE_W*k +: SAMPLE_W];
			if (k + SLOTS < MAX_STEPS && idx == STEP_W'(k + SLOTS))
				m = high[SAMPLE_W*k +: SAMPLE_W];
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: sv/bsd_poll_if.sv
// ----------------------------------------------------------------------------
// bsd_poll_if
// poll channel: one button sample and its time per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsd_poll_if import bsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] button_sample;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, output button_sample, output now_ms, input ready);
	modport sink   (input valid, input button_sample, input now_ms, output ready);
endinterface

`default_nettype wire

FILE: sv/bsd_result_if.sv
// ----------------------------------------------------------------------------
// bsd_result_if
// result channel: detection flag and progress per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsd_result_if import bsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              detected;
	logic [STEP_W-1:0] progress;

	modport source (output valid, output detected, output progress, input ready);
	modport sink   (input valid, input detected, input progress, output ready);
endinterface

`default_nettype wire

FILE: sv/bsd_apb_regs.sv
// ----------------------------------------------------------------------------
// bsd_apb_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsd_apb_regs import bsd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	output bsd_cfg_t                cfg
);

	bsd_cfg_t   cfg_q;
	reg_index_t reg_sel;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[PADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_masks_low  <= '0;
			cfg_q.step_masks_high <= '0;
			cfg_q.sequence_length <= SEQ_LEN_RESET;
			cfg_q.timeout_ms      <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_STEP_MASKS_LOW:  cfg_q.step_masks_low  <= pwdata[MASK_WORD_W-1:0];
				REG_STEP_MASKS_HIGH: cfg_q.step_masks_high <= pwdata[MASK_WORD_W-1:0];
				REG_SEQUENCE_LENGTH: cfg_q.sequence_length <= pwdata[STEP_W-1:0];
				REG_TIMEOUT_MS:      cfg_q.timeout_ms      <= pwdata[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_STEP_MASKS_LOW:  prdata = DATA_W'(cfg_q.step_masks_low);
			REG_STEP_MASKS_HIGH: prdata = DATA_W'(cfg_q.step_masks_high);
			REG_SEQUENCE_LENGTH: prdata = DATA_W'(cfg_q.sequence_length);
			REG_TIMEOUT_MS:      prdata = DATA_W'(cfg_q.timeout_ms);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/bsd_engine.sv
// ----------------------------------------------------------------------------
// bsd_engine
// input register, step state update and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bsd_engine import bsd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bsd_cfg_t cfg,
	bsd_poll_if.sink      poll,
	bsd_result_if.source  result
);

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [TIME_W-1:0]   now_s1;

	// result stage
	logic              valid_s2;
	logic              detected_s2;
	logic [STEP_W-1:0] progress_s2;

	// step state
	logic [STEP_W-1:0]   step_index_q;
	logic [TIME_W-1:0]   step_stamp_q;
	logic                armed_q;
	logic [SAMPLE_W-1:0] last_sample_q;

	logic                advance;
	logic [STEP_W-1:0]   len_eff;
	logic [TIME_W-1:0]   elapsed;
	logic                timed_out;
	logic [STEP_W-1:0]   idx_a;
	logic [TIME_W-1:0]   stamp_a;
	logic                armed_a;
	logic [SAMPLE_W-1:0] mask;
	logic                changed;
	logic [STEP_W-1:0]   idx_b;
	logic [TIME_W-1:0]   stamp_b;
	logic                armed_b;
	logic                detect;
	logic [STEP_W-1:0]   idx_n;
	logic [TIME_W-1:0]   stamp_n;
	logic                armed_n;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || advance;

	assign result.valid    = valid_s2;
	assign result.detected = detected_s2;
	assign result.progress = progress_s2;

	always_comb begin
		len_eff   = (cfg.sequence_length > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
		                                                       : cfg.sequence_length;
		elapsed   = now_s1 - step_stamp_q;
		timed_out = armed_q && (elapsed >= TIME_W'(cfg.timeout_ms));

		idx_a   = timed_out ? '0 : step_index_q;
		stamp_a = timed_out ? '0 : step_stamp_q;
		armed_a = timed_out ? 1'b0 : armed_q;

		mask    = step_mask(cfg.step_masks_low, cfg.step_masks_high, idx_a);
		changed = (sample_s1 != last_sample_q) && (sample_s1 != IDLE_SAMPLE);

		idx_b   = idx_a;
		stamp_b = stamp_a;
		armed_b = armed_a;
		if (changed) begin
			if ((sample_s1 & mask) == '0) begin
				idx_b   = idx_a + STEP_W'(1);
				stamp_b = now_s1;
				armed_b = 1'b1;
			end else begin
				idx_b   = '0;
				stamp_b = '0;
				armed_b = 1'b0;
			end
		end

		detect  = idx_b >= len_eff;
		idx_n   = detect ? '0 : idx_b;
		stamp_n = detect ? '0 : stamp_b;
		armed_n = detect ? 1'b0 : armed_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			sample_s1 <= poll.button_sample;
			now_s1    <= poll.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			detected_s2 <= detect;
			progress_s2 <= idx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_index_q  <= '0;
			step_stamp_q  <= '0;
			armed_q       <= 1'b0;
			last_sample_q <= IDLE_SAMPLE;
		end else if (advance) begin
			step_index_q  <= idx_n;
			step_stamp_q  <= stamp_n;
			armed_q       <= armed_n;
			last_sample_q <= sample_s1;
		end
	end

	`ASSERT_IMPLIES(a_idle_stamp_clear, clk, arst_n, !armed_q, step_stamp_q == '0)
	`ASSERT_IMPLIES(a_armed_has_progress, clk, arst_n, armed_q, step_index_q != '0)
	`ASSERT_IMPLIES(a_detect_clears, clk, arst_n, valid_s2 && detected_s2, progress_s2 == '0)
	`ASSERT_IMPLIES(a_progress_bound, clk, arst_n, valid_s2, progress_s2 <= STEP_W'(MAX_STEPS))
	`ASSERT_NEXT(a_state_held, clk, arst_n, !advance, $stable(step_index_q) && $stable(armed_q))

endmodule

`default_nettype wire

FILE: sv/button_sequence_detector_top.sv
// The detector takes one poll request per clock cycle while the output side is
// not stalled and returns one result request per poll, in order. A poll is
// registered in the input register on acceptance and its result in the result
// register; the step state (progress, stamp, armed flag, last sample) is updated
// combinationally between them, giving a sustained rate of one poll per cycle.
// Poll ready follows result ready combinationally while both stages hold data.
// Configuration sits at byte addresses 0, 8, 16 and 24 of a 64-bit apb-style
// port and must be written only while no poll is in flight; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
// button_sequence_detector_top
// button sequence detector with timeout, apb configuration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_sequence_detector_top import bsd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	bsd_poll_if.sink                poll,
	bsd_result_if.source            result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);

	bsd_cfg_t cfg;

	bsd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsd_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.poll   (poll),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: dv/bsd_checker.sv
// ----------------------------------------------------------------------------
// bsd_checker
// watches the poll, result and apb ports of the detector, tracks its own copy
// of the registers and step state, predicts one outcome per accepted poll and
// compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsd_checker
	import bsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	bsd_poll_if                     poll,
	bsd_result_if                   result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	input  wire logic               pready,
	output int unsigned             mismatches,
	output int unsigned             outstanding
);

	typedef struct packed {
		logic              detected;
		logic [STEP_W-1:0] progress;
	} outcome_t;

	outcome_t pending_outcomes[$];

	logic [MASK_WORD_W-1:0] masks_lo;
	logic [MASK_WORD_W-1:0] masks_hi;
	logic [STEP_W-1:0]      length_cfg;
	logic [TIMEOUT_W-1:0]   timeout_cfg;

	logic [STEP_W-1:0]      steps_matched;
	logic [TIME_W-1:0]      match_stamp;
	logic                   armed;
	logic [SAMPLE_W-1:0]    prev_sample;

	function automatic logic [SAMPLE_W-1:0] mask_for_step(input logic [STEP_W-1:0] idx);
		logic [MASK_WORD_W-1:0] word;
		int unsigned            slot;
		if (idx >= MAX_STEPS) begin
			return '0;
		end
		word = (idx < SLOTS) ? masks_lo : masks_hi;
		slot = (idx < SLOTS) ? idx : idx - SLOTS;
		return SAMPLE_W'(word >> (SAMPLE_W * slot));
	endfunction

	task automatic clear_progress();
		steps_matched = '0;
		match_stamp   = '0;
		armed         = 1'b0;
	endtask

	task automatic advance_sequence(
		input logic [SAMPLE_W-1:0] sample,
		input logic [TIME_W-1:0]   now
	);
		logic [STEP_W-1:0] len;
		logic [TIME_W-1:0] elapsed;
		outcome_t          o;
		len     = (length_cfg > MAX_STEPS) ? STEP_W'(MAX_STEPS) : length_cfg;
		elapsed = now - match_stamp;
		if (armed && elapsed >= TIME_W'(timeout_cfg)) begin
			clear_progress();
		end
		if (sample != prev_sample && sample != IDLE_SAMPLE) begin
			if ((sample & mask_for_step(steps_matched)) == '0) begin
				if (steps_matched < 4'd15) begin
					steps_matched = steps_matched + 1'b1;
				end
				match_stamp = now;
				armed       = 1'b1;
			end else begin
				clear_progress();
			end
		end
		prev_sample = sample;
		o.detected  = 1'b0;
		if (steps_matched >= len) begin
			clear_progress();
			o.detected = 1'b1;
		end
		o.progress = steps_matched;
		pending_outcomes.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		outcome_t want;
		if (!arst_n) begin
			pending_outcomes.delete();
			masks_lo    = '0;
			masks_hi    = '0;
			length_cfg  = SEQ_LEN_RESET;
			timeout_cfg = TIMEOUT_RESET;
			clear_progress();
			prev_sample = IDLE_SAMPLE;
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[4:3]))
					REG_STEP_MASKS_LOW:  masks_lo    = pwdata[MASK_WORD_W-1:0];
					REG_STEP_MASKS_HIGH: masks_hi    = pwdata[MASK_WORD_W-1:0];
					REG_SEQUENCE_LENGTH: length_cfg  = pwdata[STEP_W-1:0];
					REG_TIMEOUT_MS:      timeout_cfg = pwdata[TIMEOUT_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no poll pending: detected %0d progress %0d",
						result.detected, result.progress);
					mismatches++;
				end else begin
					want = pending_outcomes.pop_front();
					if (result.detected !== want.detected) begin
						$error("detected: expected %0d, actual %0d", want.detected,
							result.detected);
						mismatches++;
					end
					if (result.progress !== want.progress) begin
						$error("progress: expected %0d, actual %0d", want.progress,
							result.progress);
						mismatches++;
					end
				end
			end
			if (poll.valid && poll.ready) begin
				advance_sequence(poll.button_sample, poll.now_ms);
			end
			outstanding = pending_outcomes.size();
		end
	end

endmodule

`default_nettype wire

FILE: dv/button_sequence_detector_top_tb.sv
// ----------------------------------------------------------------------------
// button_sequence_detector_top_tb
// drives polls and apb register writes into the detector: a directed run over
// idle and repeated samples, time wrap, timeout boundaries, length changes
// and extreme masks, then random phases of button sequences mixed with noise,
// each phase under its own register setting; the checker scores the results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_sequence_detector_top_tb;
	import bsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_POLLS = 250;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned idle_pct = 27;
	int unsigned stall_pct = 27;

	logic [SAMPLE_W-1:0]  stim_masks[MAX_STEPS];
	int unsigned          eff_len;
	logic [TIMEOUT_W-1:0] stim_timeout;
	logic [SAMPLE_W-1:0]  last_sent;
	logic [TIME_W-1:0]    now_cur;
	int unsigned          seq_pos;

	bsd_poll_if   poll();
	bsd_result_if result();

	button_sequence_detector_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bsd_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll        (poll),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(negedge clk) begin
		result.ready = ($urandom_range(99) >= stall_pct);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic apb_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// stop polling and wait until every result is back
	task automatic drain();
		@(negedge clk);
		poll.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_length(input logic [STEP_W-1:0] len);
		apb_write(REG_SEQUENCE_LENGTH, {DATA_W'($urandom) << STEP_W} | DATA_W'(len));
		eff_len = (len > MAX_STEPS) ? MAX_STEPS : len;
		seq_pos = 0;
	endtask

	task automatic set_config(
		input logic [SAMPLE_W-1:0]  masks[MAX_STEPS],
		input logic [STEP_W-1:0]    len,
		input logic [TIMEOUT_W-1:0] tmo
	);
		logic [MASK_WORD_W-1:0] lo;
		logic [MASK_WORD_W-1:0] hi;
		lo = '0;
		hi = '0;
		for (int k = 0; k < SLOTS; k++) begin
			lo[SAMPLE_W*k +: SAMPLE_W] = masks[k];
			hi[SAMPLE_W*k +: SAMPLE_W] = masks[k + SLOTS];
		end
		// junk above the register width must be dropped
		apb_write(REG_STEP_MASKS_LOW, {9'($urandom), lo});
		apb_write(REG_STEP_MASKS_HIGH, {9'($urandom), hi});
		apb_write(REG_TIMEOUT_MS, {48'({$urandom, $urandom}), tmo});
		set_length(len);
		stim_masks   = masks;
		stim_timeout = tmo;
	endtask

	task automatic send_poll(input logic [SAMPLE_W-1:0] sample, input logic [TIME_W-1:0] now);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			poll.valid = 1'b0;
			@(negedge clk);
		end
		poll.valid         = 1'b1;
		poll.button_sample = sample;
		poll.now_ms        = now;
		do @(posedge clk); while (!poll.ready);
		last_sent = sample;
		now_cur   = now;
	endtask

	// press for the next step, or a release when no fresh press fits
	task automatic press_next_step();
		logic [SAMPLE_W-1:0] mask;
		logic [SAMPLE_W-1:0] s;
		mask = stim_masks[seq_pos];
		s    = IDLE_SAMPLE;
		for (int tries = 0; tries < 8 && (s == IDLE_SAMPLE || s == last_sent); tries++) begin
			s = SAMPLE_W'($urandom) & ~mask;
		end
		if (s == IDLE_SAMPLE || s == last_sent) begin
			send_poll(IDLE_SAMPLE, now_cur + $urandom_range(0, stim_timeout / 4));
		end else begin
			send_poll(s, now_cur + $urandom_range(0, stim_timeout / 4));
			seq_pos++;
			if (seq_pos >= eff_len) begin
				seq_pos = 0;
			end
		end
	endtask

	task automatic run_phase(input int unsigned polls);
		int unsigned pick;
		for (int unsigned n = 0; n < polls; n++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if (last_sent != IDLE_SAMPLE && $urandom_range(1) == 0) begin
					send_poll(IDLE_SAMPLE, now_cur + $urandom_range(0, stim_timeout / 4));
				end else begin
					press_next_step();
				end
			end else if (pick < 80) begin
				send_poll(last_sent, now_cur + $urandom_range(0, 3));
			end else if (pick < 92) begin
				send_poll(SAMPLE_W'($urandom), now_cur + $urandom_range(0, 50));
				seq_pos = 0;
			end else if (pick < 97) begin
				// around the timeout boundary
				send_poll(last_sent, now_cur + stim_timeout - 1 + $urandom_range(0, 2));
				seq_pos = 0;
			end else begin
				send_poll(SAMPLE_W'($urandom), $urandom);
				seq_pos = 0;
			end
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] sparse_mask();
		return SAMPLE_W'($urandom & $urandom & $urandom);
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] masks[MAX_STEPS];
		logic [TIME_W-1:0]   t;
		poll.valid         = 1'b0;
		poll.button_sample = IDLE_SAMPLE;
		poll.now_ms        = '0;
		result.ready       = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		last_sent          = IDLE_SAMPLE;
		now_cur            = '0;
		seq_pos            = 0;
		eff_len            = MAX_STEPS;
		stim_timeout       = TIMEOUT_RESET;
		foreach (stim_masks[k]) stim_masks[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: empty masks, full length, time across the wrap
		t = 32'hFFFF_FE00;
		send_poll(IDLE_SAMPLE, t);
		send_poll(11'h000, t + 100);
		send_poll(11'h000, t + 200);
		send_poll(IDLE_SAMPLE, t + 300);
		send_poll(11'h7FE, t + 400);
		send_poll(11'h555, t + 600);
		send_poll(11'h2AA, t + 700);
		// timeout reached exactly, then one short of it
		send_poll(IDLE_SAMPLE, t + 1700);
		send_poll(11'h000, t + 1800);
		send_poll(IDLE_SAMPLE, t + 2799);
		for (int k = 0; k < 9; k++) begin
			send_poll(IDLE_SAMPLE ^ SAMPLE_W'(1 << k), t + 2800 + k);
		end

		// all-pressed mask, empty mask, longest timeout
		drain();
		foreach (masks[k]) masks[k] = sparse_mask();
		masks[0] = 11'h003;
		masks[1] = 11'h7FF;
		masks[2] = 11'h000;
		set_config(masks, 4'd3, 16'hFFFF);
		send_poll(11'h7FC, now_cur + 10);
		send_poll(11'h7FD, now_cur + 10);
		send_poll(11'h7FC, now_cur + 10);
		send_poll(11'h000, now_cur + 10);
		send_poll(IDLE_SAMPLE, now_cur + 10);
		send_poll(11'h7F0, now_cur + 10);
		send_poll(11'h7FC, now_cur + 10);
		send_poll(11'h000, now_cur + 10);
		// length dropped under progress, then length zero
		drain();
		set_length(4'd1);
		send_poll(IDLE_SAMPLE, now_cur + 10);
		drain();
		set_length(4'd0);
		send_poll(11'h000, now_cur + 10);
		send_poll(IDLE_SAMPLE, now_cur + 10);

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			foreach (masks[k]) masks[k] = sparse_mask();
			case (phase)
				0: set_config(masks, 4'd4, 16'd1000);
				1: begin
					foreach (masks[k]) masks[k] = 11'h7FF;
					set_config(masks, 4'd10, 16'hFFFF);
					idle_pct  = 0;
					stall_pct = 0;
				end
				2: begin
					foreach (masks[k]) masks[k] = '0;
					set_config(masks, 4'd0, 16'd500);
				end
				3: set_config(masks, 4'd15, 16'd0);
				4: set_config(masks, 4'd1, 16'($urandom));
				default: set_config(masks, 4'($urandom_range(1, 10)),
					16'($urandom_range(20, 3000)));
			endcase
			if (phase == 4) begin
				run_phase(PHASE_POLLS / 2);
				drain();
				run_phase(PHASE_POLLS / 2);
			end else begin
				run_phase(PHASE_POLLS);
			end
			idle_pct  = 27;
			stall_pct = 27;
		end

		drain();
		repeat (5) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/bsd_pkg.sv
sv/bsd_poll_if.sv
sv/bsd_result_if.sv
sv/bsd_apb_regs.sv
sv/bsd_engine.sv
sv/button_sequence_detector_top.sv
dv/bsd_checker.sv
dv/button_sequence_detector_top_tb.sv
